// ===== hw/rtl/mrel_pkg.sv =====
package mrel_pkg;

   localparam int RING_COUNT_DEF = 3;
   localparam int RING_DEPTH_DEF = 64;
   // ring_sel is 2 bits wide, so at most four rings can be addressed
   localparam int RING_MAX = 4;

   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_POP = 1'b1;

   typedef struct packed {
      logic        func;
      logic [1:0]  ring_sel;
      logic [31:0] time_ms;
      logic [7:0]  event_kind;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [1:0]  from_ring;
      logic [31:0] out_time;
      logic [7:0]  out_kind;
      logic [31:0] out_a;
      logic [31:0] out_b;
      logic [31:0] out_c;
      logic [31:0] drop_total;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] time_ms;
      logic [7:0]  kind;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } entry_type;

endpackage

// ===== hw/rtl/mrel_if.sv =====
interface mrel_req_if;
   import mrel_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mrel_rsp_if;
   import mrel_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mrel_ram.sv =====
module mrel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/multi_ring_event_log_merge_top.sv =====
// Event log of RING_COUNT FIFO rings, RING_DEPTH entries each, all entries held in one
// dual-port RAM (one write and one registered read port). A put (func 0) appends to the
// ring named by ring_sel; a full ring drops the entry and bumps the wrapping drop counter,
// an out-of-range ring_sel is ignored. A pop (func 1) returns the head with the smallest
// timestamp, lowest ring on ties, or ok = 0 when all rings are empty. One item at a time;
// a pop fetches the head of each ring in turn through the single RAM read port and
// compares it as it arrives. The result sits in an output register, so the block takes
// the next word while a result is still waiting. No clearing pass after reset.
module multi_ring_event_log_merge_top #(
   parameter int RING_COUNT = mrel_pkg::RING_COUNT_DEF,
   parameter int RING_DEPTH = mrel_pkg::RING_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   mrel_req_if.sink  req,
   mrel_rsp_if.source rsp
);
   import mrel_pkg::*;

   localparam int SLOTS  = RING_COUNT * RING_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int SCAN_W = $clog2(RING_COUNT + 1);

   typedef struct packed {
      logic             wrap;
      logic [IDX_W-1:0] idx;
   } ptr_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PUT  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   req_word_type req_ff, req_in;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   ptr_type      wr_ptr_ff [RING_MAX];
   ptr_type      wr_ptr_in [RING_MAX];
   ptr_type      rd_ptr_ff [RING_MAX];
   ptr_type      rd_ptr_in [RING_MAX];
   logic [31:0]  drop_ff, drop_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic         rd_pend_ff, rd_pend_in;
   logic [1:0]   rd_ring_ff, rd_ring_in;
   logic         found_ff, found_in;
   logic [1:0]   best_ring_ff, best_ring_in;
   entry_type    best_ff, best_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   entry_type         ram_rdata;

   logic       slot_free;
   logic [1:0] scan_ring;
   logic [1:0] sel;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] ring,
                                                   input logic [IDX_W-1:0] idx);
      return ADDR_W'(ring) * ADDR_W'(RING_DEPTH) + ADDR_W'(idx);
   endfunction

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type n;
      n = p;
      if (p.idx == IDX_W'(RING_DEPTH - 1)) begin
         n.idx  = '0;
         n.wrap = ~p.wrap;
      end else begin
         n.idx = p.idx + 1'b1;
      end
      return n;
   endfunction

   mrel_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign scan_ring = 2'(scan_ff);
   assign sel       = req_ff.ring_sel;

   assign ram_waddr = slot_addr(sel, wr_ptr_ff[sel].idx);
   assign ram_wdata = '{time_ms: req_ff.time_ms, kind: req_ff.event_kind,
                        a: req_ff.word_a, b: req_ff.word_b, c: req_ff.word_c};
   assign ram_raddr = slot_addr(scan_ring, rd_ptr_ff[scan_ring].idx);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      drop_in      = drop_ff;
      scan_in      = scan_ff;
      rd_pend_in   = rd_pend_ff;
      rd_ring_in   = rd_ring_ff;
      found_in     = found_ff;
      best_ring_in = best_ring_ff;
      best_in      = best_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               req_in     = req.data;
               scan_in    = '0;
               rd_pend_in = 1'b0;
               found_in   = 1'b0;
               state_in   = (req.data.func == FUNC_POP) ? ST_SCAN : ST_PUT;
            end
         end
         ST_PUT: begin
            if (slot_free) begin
               rsp_in = '0;
               if ({1'b0, sel} < 3'(RING_COUNT)) begin
                  // full: same index, opposite wrap bit
                  if (wr_ptr_ff[sel].wrap != rd_ptr_ff[sel].wrap &&
                      wr_ptr_ff[sel].idx == rd_ptr_ff[sel].idx) begin
                     drop_in = drop_ff + 32'd1;
                  end else begin
                     ram_we         = 1'b1;
                     wr_ptr_in[sel] = ptr_next(wr_ptr_ff[sel]);
                     rsp_in.ok      = 1'b1;
                  end
               end
               rsp_in.drop_total = drop_in;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // compare the head fetched last cycle, strict < keeps the lower ring on ties
            if (rd_pend_ff && (!found_ff || ram_rdata.time_ms < best_ff.time_ms)) begin
               found_in     = 1'b1;
               best_in      = ram_rdata;
               best_ring_in = rd_ring_ff;
            end
            if (scan_ff < SCAN_W'(RING_COUNT)) begin
               ram_re     = 1'b1;
               rd_pend_in = (wr_ptr_ff[scan_ring] != rd_ptr_ff[scan_ring]);
               rd_ring_in = scan_ring;
               scan_in    = scan_ff + 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_in = '0;
               if (found_ff) begin
                  rsp_in.ok        = 1'b1;
                  rsp_in.from_ring = best_ring_ff;
                  rsp_in.out_time  = best_ff.time_ms;
                  rsp_in.out_kind  = best_ff.kind;
                  rsp_in.out_a     = best_ff.a;
                  rsp_in.out_b     = best_ff.b;
                  rsp_in.out_c     = best_ff.c;
                  rd_ptr_in[best_ring_ff] = ptr_next(rd_ptr_ff[best_ring_ff]);
               end
               rsp_in.drop_total = drop_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         drop_ff      <= '0;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         for (int i = 0; i < RING_MAX; i++) begin
            wr_ptr_ff[i] <= '0;
            rd_ptr_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         drop_ff      <= drop_in;
         scan_ff      <= scan_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      rd_ring_ff   <= rd_ring_in;
      best_ring_ff <= best_ring_in;
      best_ff      <= best_in;
   end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import mrel_pkg::*;

   localparam int RINGS = RING_COUNT_DEF;
   localparam int DEPTH = RING_DEPTH_DEF;
   localparam int PTR_W = $clog2(2 * DEPTH);
   localparam int RANDOM_WORDS = 600;
   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_CYCLES = 20;
   localparam int REPORT_MAX = 10;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIX} phase_kind_type;

   typedef struct {
      req_word_type word;
      bit           hold;   // wait for all outstanding results before sending
   } log_item_type;

   logic clock = 1'b0;
   logic reset;

   mrel_req_if req_ch ();
   mrel_rsp_if rsp_ch ();

   multi_ring_event_log_merge_top #(
      .RING_COUNT(RINGS),
      .RING_DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always #5 clock = ~clock;

   // predicted contents of the rings
   entry_type        ring_mem [RINGS][DEPTH];
   logic [PTR_W-1:0] ring_wr [RINGS];
   logic [PTR_W-1:0] ring_rd [RINGS];
   logic [31:0]      drop_cnt;

   log_item_type event_words_q[$];
   rsp_word_type pending_rsp_q[$];

   logic req_fire = 1'b0;
   int   total_words = 0;
   int   accepted_count = 0;
   int   rsp_count = 0;
   int   fail_count = 0;
   int   idle_cycles = 0;
   int   send_gap = 0;
   int   send_quiet = 0;
   int   stall_left = 0;
   int   stall_quiet = 0;

   function automatic rsp_word_type ring_log_predict(req_word_type w);
      rsp_word_type     r;
      logic [PTR_W-1:0] fill;
      entry_type        head;
      logic [31:0]      best_time;
      int               sel;
      int               best;
      int               k;
      bit               found;
      r = '0;
      found = 1'b0;
      best = 0;
      best_time = '0;
      sel = int'(w.ring_sel);
      if (w.func == FUNC_PUT) begin
         if (sel < RINGS) begin
            fill = ring_wr[sel] - ring_rd[sel];
            if (int'(fill) >= DEPTH) begin
               drop_cnt = drop_cnt + 32'd1;
            end else begin
               ring_mem[sel][int'(ring_wr[sel]) % DEPTH] = '{time_ms: w.time_ms,
                  kind: w.event_kind, a: w.word_a, b: w.word_b, c: w.word_c};
               ring_wr[sel] = ring_wr[sel] + 1'b1;
               r.ok = 1'b1;
            end
         end
      end else begin
         for (k = 0; k < RINGS; k++) begin
            if (ring_wr[k] != ring_rd[k]) begin
               head = ring_mem[k][int'(ring_rd[k]) % DEPTH];
               if (!found || head.time_ms < best_time) begin
                  found = 1'b1;
                  best = k;
                  best_time = head.time_ms;
               end
            end
         end
         if (found) begin
            head = ring_mem[best][int'(ring_rd[best]) % DEPTH];
            r.ok = 1'b1;
            r.from_ring = 2'(best);
            r.out_time = head.time_ms;
            r.out_kind = head.kind;
            r.out_a = head.a;
            r.out_b = head.b;
            r.out_c = head.c;
            ring_rd[best] = ring_rd[best] + 1'b1;
         end
      end
      r.drop_total = drop_cnt;
      return r;
   endfunction

   function automatic int pick_gap(inout int quiet_left);
      int roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // small timestamps on purpose, so heads often tie
   function automatic logic [31:0] pick_time();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5: return 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type put_word(logic [1:0] ring, logic [31:0] stamp);
      req_word_type w;
      w.func = FUNC_PUT;
      w.ring_sel = ring;
      w.time_ms = stamp;
      w.event_kind = 8'($urandom_range(0, 255));
      w.word_a = $urandom;
      w.word_b = $urandom;
      w.word_c = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      return w;
   endfunction

   // unused fields of a pop carry noise
   function automatic req_word_type pop_word();
      req_word_type w;
      w = put_word(2'($urandom_range(0, 3)), $urandom);
      w.func = FUNC_POP;
      return w;
   endfunction

   function automatic req_word_type any_word();
      if ($urandom_range(0, 1) == 0) return put_word(2'($urandom_range(0, 3)), pick_time());
      return pop_word();
   endfunction

   task automatic add_word(req_word_type w, bit hold);
      log_item_type item;
      item.word = w;
      item.hold = hold;
      event_words_q.push_back(item);
   endtask

   task automatic build_stimulus();
      req_word_type   w;
      phase_kind_type phase;
      logic [1:0]     ring;
      int             target;
      int             n;
      int             k;
      bit             hold;
      // pop with every ring empty
      add_word(pop_word(), 1'b0);
      // put to the ring index past the last ring, all ones
      w = put_word(2'd3, '1);
      w.event_kind = '1;
      w.word_a = '1;
      w.word_b = '1;
      w.word_c = '1;
      add_word(w, 1'b0);
      w.ring_sel = 2'd0;
      add_word(w, 1'b0);
      w = '0;
      w.func = FUNC_PUT;
      w.ring_sel = 2'd1;
      add_word(w, 1'b0);
      add_word(put_word(2'd2, 32'd5), 1'b0);
      add_word(put_word(2'd0, 32'd5), 1'b0);
      add_word(put_word(2'd2, 32'd0), 1'b0);
      for (k = 0; k < 3; k++) add_word(pop_word(), 1'b0);
      // equal heads on rings 1 and 2, lower index wins
      add_word(put_word(2'd1, 32'd7), 1'b0);
      add_word(put_word(2'd2, 32'd7), 1'b0);
      for (k = 0; k < 5; k++) add_word(pop_word(), 1'b0);

      target = event_words_q.size() + RANDOM_WORDS;
      hold = 1'b1;
      while (event_words_q.size() < target) begin
         phase = phase_kind_type'($urandom_range(0, 2));
         case (phase)
            PHASE_FILL: begin
               // push one ring past full to provoke drops
               ring = 2'($urandom_range(0, RINGS - 1));
               n = $urandom_range(60, 90);
               for (k = 0; k < n; k++) begin
                  if ($urandom_range(0, 9) != 0) add_word(put_word(ring, pick_time()), hold);
                  else add_word(any_word(), hold);
                  hold = 1'b0;
               end
            end
            PHASE_DRAIN: begin
               n = $urandom_range(20, 100);
               for (k = 0; k < n; k++) begin
                  if ($urandom_range(0, 9) != 0) add_word(pop_word(), hold);
                  else add_word(any_word(), hold);
                  hold = 1'b0;
               end
            end
            default: begin
               n = $urandom_range(20, 50);
               for (k = 0; k < n; k++) begin
                  add_word(any_word(), hold);
                  hold = 1'b0;
               end
            end
         endcase
         hold = ($urandom_range(0, 3) == 0);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap--;
         end else if (event_words_q.size() != 0 &&
                      !(event_words_q[0].hold && pending_rsp_q.size() != 0)) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= event_words_q[0].word;
            void'(event_words_q.pop_front());
            send_gap = pick_gap(send_quiet);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left = pick_gap(stall_quiet);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_word_type exp_word;
      rsp_word_type got;
      string        bad;
      if (reset) begin
         req_fire <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (pending_rsp_q.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("rsp word %0d arrived with nothing pending", rsp_count);
               fail_count++;
            end else begin
               exp_word = pending_rsp_q.pop_front();
               bad = "";
               if (got.ok !== exp_word.ok) bad = {bad, " ok"};
               if (got.from_ring !== exp_word.from_ring) bad = {bad, " from_ring"};
               if (got.out_time !== exp_word.out_time) bad = {bad, " out_time"};
               if (got.out_kind !== exp_word.out_kind) bad = {bad, " out_kind"};
               if (got.out_a !== exp_word.out_a) bad = {bad, " out_a"};
               if (got.out_b !== exp_word.out_b) bad = {bad, " out_b"};
               if (got.out_c !== exp_word.out_c) bad = {bad, " out_c"};
               if (got.drop_total !== exp_word.drop_total) bad = {bad, " drop_total"};
               if (bad != "") begin
                  if (fail_count < REPORT_MAX) begin
                     $display("rsp word %0d mismatch in%s", rsp_count, bad);
                     $display("  exp ok=%0d ring=%0d time=%h kind=%h a=%h b=%h c=%h drops=%0d",
                              exp_word.ok, exp_word.from_ring, exp_word.out_time,
                              exp_word.out_kind, exp_word.out_a, exp_word.out_b,
                              exp_word.out_c, exp_word.drop_total);
                     $display("  got ok=%0d ring=%0d time=%h kind=%h a=%h b=%h c=%h drops=%0d",
                              got.ok, got.from_ring, got.out_time, got.out_kind,
                              got.out_a, got.out_b, got.out_c, got.drop_total);
                  end
                  fail_count++;
               end
            end
            rsp_count++;
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_rsp_q.push_back(ring_log_predict(req_ch.data));
            accepted_count++;
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin
      int k;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      drop_cnt = '0;
      for (k = 0; k < RINGS; k++) begin
         ring_wr[k] = '0;
         ring_rd[k] = '0;
      end
      build_stimulus();
      total_words = event_words_q.size();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (!(accepted_count == total_words && pending_rsp_q.size() == 0) &&
             idle_cycles < IDLE_LIMIT)
         @(negedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("multi_ring_event_log_merge_top regression: fail");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         if (fail_count == 0)
            $display("multi_ring_event_log_merge_top regression: pass");
         else
            $display("multi_ring_event_log_merge_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== multi_ring_event_log_merge_top.f =====
hw/rtl/mrel_pkg.sv
hw/rtl/mrel_if.sv
hw/rtl/mrel_ram.sv
hw/rtl/multi_ring_event_log_merge_top.sv
bench/tb.sv
